/* rtl/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants for the first-fit heap allocator: default geometry,
// port widths, operation and status codes.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int HEAP_WORDS   = 8192;
    localparam int PAGE_WORDS   = 512;
    localparam int HEADER_WORDS = 3;

    localparam int ADDR_W   = 64;
    localparam int BYTES_W  = 17;
    localparam int WORDS_W  = BYTES_W - 2;
    localparam int STATUS_W = 2;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 64'hffff_8100_0000_0000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOM  = 2'd2;

endpackage

/* rtl/ffa_req_if.sv */
// ----------------------------------------------------------------------------
// ffa_req_if
// Request channel: valid/ready handshake carrying one allocate or free word.
// ----------------------------------------------------------------------------
interface ffa_req_if;

    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [ffa_pkg::BYTES_W-1:0]  request_bytes;
    logic [ffa_pkg::ADDR_W-1:0]   free_address;

    modport source (
        output valid,
        output operation,
        output request_bytes,
        output free_address,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  request_bytes,
        input  free_address,
        output ready
    );

endinterface

/* rtl/ffa_rsp_if.sv */
// ----------------------------------------------------------------------------
// ffa_rsp_if
// Response channel: valid/ready handshake carrying address and status.
// ----------------------------------------------------------------------------
interface ffa_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [ffa_pkg::ADDR_W-1:0]    address;
    logic [ffa_pkg::STATUS_W-1:0]  status;

    modport source (
        output valid,
        output address,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  address,
        input  status,
        output ready
    );

endinterface

/* rtl/ffa_ram.sv */
// ----------------------------------------------------------------------------
// ffa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. Read of an address written on the same edge
// returns the old contents.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/first_fit_heap_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// Boundary-tag first-fit heap allocator. Chunk headers live in one RAM
// indexed by heap word; a sequencer walks the chunk chain one header per
// cycle, then splits, grows or merges with read-modify-write accesses.
// ----------------------------------------------------------------------------
// Alloc: the walk, then S_FIT and, on a split, S_SPL1 and S_SPL2; a growing
//   heap first tries larger page multiples in S_GROW; a zero-size request goes straight to S_DONE.
// Free: S_FCHK, the walk, then S_FNXT, S_FPRV and S_FFIN; a rejected free ends sooner.
// The chain walk reads one header per cycle through the header RAM port.
// Throughput: one word at a time; the next request is taken once the
//   previous result sits in the output register.
// Reset: states S_INIT0 and S_INIT1 write the initial head and tail headers, ready is low.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
    parameter int HEAP_WORDS   = ffa_pkg::HEAP_WORDS,
    parameter int PAGE_WORDS   = ffa_pkg::PAGE_WORDS,
    parameter int HEADER_WORDS = ffa_pkg::HEADER_WORDS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ffa_req_if.sink                    req,
    ffa_rsp_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [ffa_pkg::ADDR_W-1:0] cfg_wdata
);

    localparam int ADDR_W  = ffa_pkg::ADDR_W;
    localparam int BYTES_W = ffa_pkg::BYTES_W;
    localparam int WORDS_W = ffa_pkg::WORDS_W;
    localparam int AW      = $clog2(HEAP_WORDS);
    localparam int SIZE_W  = $clog2(HEAP_WORDS + 1);
    localparam int POS_W   = SIZE_W + 1;
    localparam int GW      = $clog2(HEAP_WORDS + PAGE_WORDS + 1);
    localparam int NW      = ((SIZE_W > WORDS_W) ? SIZE_W : WORDS_W) + 1;
    localparam int XW      = ((NW > GW) ? NW : GW) + 1;
    localparam int OW      = ADDR_W - 3;

    localparam logic [3:0] S_INIT0 = 4'd0;
    localparam logic [3:0] S_INIT1 = 4'd1;
    localparam logic [3:0] S_IDLE  = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_GROW  = 4'd4;
    localparam logic [3:0] S_FIT   = 4'd5;
    localparam logic [3:0] S_SPL1  = 4'd6;
    localparam logic [3:0] S_SPL2  = 4'd7;
    localparam logic [3:0] S_FCHK  = 4'd8;
    localparam logic [3:0] S_FWALK = 4'd9;
    localparam logic [3:0] S_FNXT  = 4'd10;
    localparam logic [3:0] S_FPRV  = 4'd11;
    localparam logic [3:0] S_FFIN  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] prev;
    } hdr_t;

    localparam int ENT_W = $bits(hdr_t);

    // control state
    logic [3:0]                     state_reg, state_next;
    logic                           out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0]              limit_reg, limit_next;
    logic [ADDR_W-1:0]              base_reg, base_next;

    // payload / working registers
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [WORDS_W-1:0]             words_reg, words_next;
    logic [SIZE_W-1:0]              cur_size_reg, cur_size_next;
    logic [SIZE_W-1:0]              cur_prev_reg, cur_prev_next;
    logic [SIZE_W-1:0]              a_size_reg, a_size_next;
    logic [POS_W-1:0]               aft_reg, aft_next;
    logic [POS_W-1:0]               prv_reg, prv_next;
    logic                           do_prv_reg, do_prv_next;
    logic                           mrg_nxt_reg, mrg_nxt_next;
    logic [AW-1:0]                  tgt_reg, tgt_next;
    logic [GW-1:0]                  grow_reg, grow_next;
    logic [ADDR_W-1:0]              faddr_reg, faddr_next;
    logic [ADDR_W-1:0]              res_addr_reg, res_addr_next;
    logic [ffa_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [ADDR_W-1:0]              out_addr_reg, out_addr_next;
    logic [ffa_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;

    // RAM port
    logic                           ram_we;
    logic [POS_W-1:0]               wr_pos;
    logic [POS_W-1:0]               rd_pos;
    hdr_t                           wr_hdr;
    hdr_t                           rd_hdr;
    logic [ENT_W-1:0]               ram_rdata;

    // datapath
    logic [BYTES_W:0]               bsum;
    logic [WORDS_W-1:0]             words_in;
    logic [NW-1:0]                  need_x;
    logic [POS_W-1:0]               walk_nxt;
    logic                           walk_end;
    logic                           fit_ok;
    logic [XW-1:0]                  target_x;
    logic                           grow_over;
    logic                           grow_done;
    logic [SIZE_W-1:0]              csz;
    logic [SIZE_W-1:0]              rest;
    logic                           rest_nz;
    logic [POS_W-1:0]               cur_end;
    logic [POS_W-1:0]               pay_pos;
    logic [ADDR_W-1:0]              alloc_addr;
    logic [ADDR_W-1:0]              off;
    logic [OW-1:0]                  off_w;
    logic                           free_bad;
    logic [AW-1:0]                  free_tgt;
    logic                           prv_ok;
    logic [POS_W-1:0]               prv_pos;
    logic                           merge_prev;
    logic [SIZE_W-1:0]              merged_sz;
    logic [SIZE_W-1:0]              final_sz;
    logic [POS_W-1:0]               fin_pos;

    ffa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (HEAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_pos[AW-1:0]),
        .wdata (wr_hdr),
        .raddr (rd_pos[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_hdr = hdr_t'(ram_rdata);

    assign bsum     = {1'b0, req.request_bytes} + (BYTES_W + 1)'(7);
    assign words_in = bsum[BYTES_W:3];
    assign need_x   = NW'(words_reg) + NW'(HEADER_WORDS);

    assign walk_nxt = pos_reg + POS_W'(HEADER_WORDS) + POS_W'(rd_hdr.size);
    assign walk_end = walk_nxt >= POS_W'(HEAP_WORDS);
    assign fit_ok   = !rd_hdr.used && (NW'(rd_hdr.size) >= need_x);

    // page growth: least page multiple covering the request plus two headers
    assign target_x  = XW'(words_reg) + XW'(2 * HEADER_WORDS);
    assign grow_over = (XW'(limit_reg) + XW'(grow_reg)) > XW'(HEAP_WORDS);
    assign grow_done = XW'(grow_reg) >= target_x;
    assign csz       = SIZE_W'(grow_reg - GW'(HEADER_WORDS));

    assign rest    = cur_size_reg - SIZE_W'(need_x);
    assign rest_nz = rest != '0;
    assign cur_end = pos_reg + POS_W'(HEADER_WORDS) + POS_W'(cur_size_reg);

    assign pay_pos    = pos_reg + POS_W'(HEADER_WORDS);
    assign alloc_addr = base_reg + ADDR_W'({pay_pos, 3'b000});

    assign off      = faddr_reg - base_reg;
    assign off_w    = off[ADDR_W-1:3];
    assign free_bad = (off[2:0] != 3'b000) || (off_w < OW'(HEADER_WORDS))
                      || (off_w >= OW'(HEAP_WORDS + HEADER_WORDS));
    assign free_tgt = AW'(off_w - OW'(HEADER_WORDS));

    // previous chunk exists only if its tag does not reach below word 0
    assign prv_ok  = (pos_reg != '0)
                     && ((POS_W'(cur_prev_reg) + POS_W'(HEADER_WORDS)) <= pos_reg);
    assign prv_pos = pos_reg - POS_W'(HEADER_WORDS) - POS_W'(cur_prev_reg);

    assign merge_prev = do_prv_reg && !rd_hdr.used;
    assign merged_sz  = merge_prev ? (rd_hdr.size + cur_size_reg + SIZE_W'(HEADER_WORDS))
                                   : cur_size_reg;
    assign final_sz   = merged_sz + (mrg_nxt_reg ? (a_size_reg + SIZE_W'(HEADER_WORDS))
                                                 : '0);
    assign fin_pos    = mrg_nxt_reg ? (aft_reg + POS_W'(HEADER_WORDS) + POS_W'(a_size_reg))
                                    : aft_reg;

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.address = out_addr_reg;
    assign rsp.status = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        base_next       = cfg_we ? cfg_wdata : base_reg;
        pos_next        = pos_reg;
        words_next      = words_reg;
        cur_size_next   = cur_size_reg;
        cur_prev_next   = cur_prev_reg;
        a_size_next     = a_size_reg;
        aft_next        = aft_reg;
        prv_next        = prv_reg;
        do_prv_next     = do_prv_reg;
        mrg_nxt_next    = mrg_nxt_reg;
        tgt_next        = tgt_reg;
        grow_next       = grow_reg;
        faddr_next      = faddr_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        wr_pos          = '0;
        wr_hdr          = '0;
        rd_pos          = '0;

        unique case (state_reg)
            S_INIT0:
            begin
                ram_we      = 1'b1;
                wr_pos      = '0;
                wr_hdr.used = 1'b0;
                wr_hdr.size = SIZE_W'(PAGE_WORDS - 2 * HEADER_WORDS);
                wr_hdr.prev = '0;
                state_next  = S_INIT1;
            end

            S_INIT1:
            begin
                ram_we      = 1'b1;
                wr_pos      = POS_W'(PAGE_WORDS - HEADER_WORDS);
                wr_hdr.used = 1'b1;
                wr_hdr.size = '0;
                wr_hdr.prev = SIZE_W'(PAGE_WORDS - 2 * HEADER_WORDS);
                state_next  = S_IDLE;
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.operation == ffa_pkg::OP_ALLOC)
                    begin
                        if (req.request_bytes == '0)
                        begin
                            res_addr_next   = '0;
                            res_status_next = ffa_pkg::ST_ZERO;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            words_next = words_in;
                            pos_next   = '0;
                            rd_pos     = '0;
                            state_next = S_WALK;
                        end
                    end
                    else
                    begin
                        faddr_next = req.free_address;
                        state_next = S_FCHK;
                    end
                end
            end

            S_WALK:
            begin
                if (rd_hdr.size == '0)
                begin
                    // reached the tail marker
                    cur_prev_next = rd_hdr.prev;
                    grow_next     = GW'(PAGE_WORDS);
                    state_next    = S_GROW;
                end
                else if (fit_ok)
                begin
                    cur_size_next = rd_hdr.size;
                    cur_prev_next = rd_hdr.prev;
                    state_next    = S_FIT;
                end
                else if (walk_end)
                begin
                    res_addr_next   = '0;
                    res_status_next = ffa_pkg::ST_OOM;
                    state_next      = S_DONE;
                end
                else
                begin
                    pos_next = walk_nxt;
                    rd_pos   = walk_nxt;
                end
            end

            S_GROW:
            begin
                if (grow_over)
                begin
                    res_addr_next   = '0;
                    res_status_next = ffa_pkg::ST_OOM;
                    state_next      = S_DONE;
                end
                else if (grow_done)
                begin
                    // new tail; the old tail header is rewritten in S_FIT
                    ram_we        = 1'b1;
                    wr_pos        = pos_reg + POS_W'(grow_reg);
                    wr_hdr.used   = 1'b1;
                    wr_hdr.size   = '0;
                    wr_hdr.prev   = csz;
                    limit_next    = SIZE_W'(XW'(limit_reg) + XW'(grow_reg));
                    cur_size_next = csz;
                    state_next    = S_FIT;
                end
                else
                begin
                    grow_next = grow_reg + GW'(PAGE_WORDS);
                end
            end

            S_FIT:
            begin
                ram_we      = 1'b1;
                wr_pos      = pos_reg;
                wr_hdr.used = 1'b1;
                wr_hdr.size = rest_nz ? SIZE_W'(words_reg) : cur_size_reg;
                wr_hdr.prev = cur_prev_reg;
                if (rest_nz)
                begin
                    cur_size_next = rest;
                    aft_next      = cur_end;
                    rd_pos        = cur_end;
                    state_next    = S_SPL1;
                end
                else
                begin
                    res_addr_next   = alloc_addr;
                    res_status_next = ffa_pkg::ST_OK;
                    state_next      = S_DONE;
                end
            end

            S_SPL1:
            begin
                ram_we      = 1'b1;
                wr_pos      = pos_reg + POS_W'(need_x);
                wr_hdr.used = 1'b0;
                wr_hdr.size = cur_size_reg;
                wr_hdr.prev = SIZE_W'(words_reg);
                rd_pos      = aft_reg;
                state_next  = S_SPL2;
            end

            S_SPL2:
            begin
                // chunk after the leftover gets its previous size updated
                if (aft_reg < POS_W'(HEAP_WORDS))
                begin
                    ram_we      = 1'b1;
                    wr_pos      = aft_reg;
                    wr_hdr.used = rd_hdr.used;
                    wr_hdr.size = rd_hdr.size;
                    wr_hdr.prev = cur_size_reg;
                end
                res_addr_next   = alloc_addr;
                res_status_next = ffa_pkg::ST_OK;
                state_next      = S_DONE;
            end

            S_FCHK:
            begin
                if (free_bad)
                begin
                    res_addr_next   = '0;
                    res_status_next = ffa_pkg::ST_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    tgt_next   = free_tgt;
                    pos_next   = '0;
                    rd_pos     = '0;
                    state_next = S_FWALK;
                end
            end

            S_FWALK:
            begin
                if (rd_hdr.size == '0)
                begin
                    res_addr_next   = '0;
                    res_status_next = ffa_pkg::ST_OK;
                    state_next      = S_DONE;
                end
                else if (pos_reg == POS_W'(tgt_reg))
                begin
                    if (rd_hdr.used)
                    begin
                        cur_size_next = rd_hdr.size;
                        cur_prev_next = rd_hdr.prev;
                        aft_next      = walk_nxt;
                        rd_pos        = walk_nxt;
                        state_next    = S_FNXT;
                    end
                    else
                    begin
                        res_addr_next   = '0;
                        res_status_next = ffa_pkg::ST_OK;
                        state_next      = S_DONE;
                    end
                end
                else if ((pos_reg > POS_W'(tgt_reg)) || walk_end)
                begin
                    res_addr_next   = '0;
                    res_status_next = ffa_pkg::ST_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    pos_next = walk_nxt;
                    rd_pos   = walk_nxt;
                end
            end

            S_FNXT:
            begin
                a_size_next  = rd_hdr.size;
                mrg_nxt_next = (aft_reg < POS_W'(HEAP_WORDS)) && !rd_hdr.used
                               && (rd_hdr.size != '0);
                do_prv_next  = prv_ok;
                prv_next     = prv_pos;
                rd_pos       = prv_pos;
                state_next   = S_FPRV;
            end

            S_FPRV:
            begin
                ram_we        = 1'b1;
                wr_pos        = merge_prev ? prv_reg : pos_reg;
                wr_hdr.used   = 1'b0;
                wr_hdr.size   = final_sz;
                wr_hdr.prev   = merge_prev ? rd_hdr.prev : cur_prev_reg;
                cur_size_next = final_sz;
                aft_next      = fin_pos;
                rd_pos        = fin_pos;
                state_next    = S_FFIN;
            end

            S_FFIN:
            begin
                if (aft_reg < POS_W'(HEAP_WORDS))
                begin
                    ram_we      = 1'b1;
                    wr_pos      = aft_reg;
                    wr_hdr.used = rd_hdr.used;
                    wr_hdr.size = rd_hdr.size;
                    wr_hdr.prev = cur_size_reg;
                end
                res_addr_next   = '0;
                res_status_next = ffa_pkg::ST_OK;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT0;
            out_valid_reg <= 1'b0;
            limit_reg     <= SIZE_W'(PAGE_WORDS);
            base_reg      <= ffa_pkg::HEAP_BASE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            limit_reg     <= limit_next;
            base_reg      <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        words_reg      <= words_next;
        cur_size_reg   <= cur_size_next;
        cur_prev_reg   <= cur_prev_next;
        a_size_reg     <= a_size_next;
        aft_reg        <= aft_next;
        prv_reg        <= prv_next;
        do_prv_reg     <= do_prv_next;
        mrg_nxt_reg    <= mrg_nxt_next;
        tgt_reg        <= tgt_next;
        grow_reg       <= grow_next;
        faddr_reg      <= faddr_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    a_limit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        limit_reg <= SIZE_W'(HEAP_WORDS))
        else $error("heap limit beyond capacity");

    a_limit_grow: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(limit_reg) |-> $past(state_reg) == S_GROW)
        else $error("heap limit changed outside growth");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> wr_pos < POS_W'(HEAP_WORDS))
        else $error("header write outside heap");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ffa_pkg::ST_OK) |-> rsp.address == '0)
        else $error("failed request with nonzero address");

    a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("accepted word not processed");

endmodule

/* bench/ffa_heap_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffa_heap_checker
// Watches the request, reply and config ports of the allocator, keeps its
// own boundary-tag heap image, works out the reply to every accepted
// request and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module ffa_heap_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    ffa_req_if                         req,
    ffa_rsp_if                         rsp,
    input  logic                       cfg_we,
    input  logic [ffa_pkg::ADDR_W-1:0] cfg_wdata,
    output int                         errors,
    output int                         pending
);

    import ffa_pkg::*;

    localparam int SIZE_W    = $clog2(HEAP_WORDS) + 1;
    localparam int HEAD_SIZE = PAGE_WORDS - 2 * HEADER_WORDS;

    typedef struct packed {
        logic [ADDR_W-1:0]   address;
        logic [STATUS_W-1:0] status;
    } heap_reply_t;

    bit                chunk_used [HEAP_WORDS];
    logic [SIZE_W-1:0] chunk_size [HEAP_WORDS];
    logic [SIZE_W-1:0] chunk_prev [HEAP_WORDS];
    int unsigned       heap_limit;
    logic [ADDR_W-1:0] heap_base_q;

    heap_reply_t       heap_reply_q [$];
    int                err_count = 0;

    function automatic int unsigned chunk_end(input int unsigned pos);
        return pos + HEADER_WORDS + chunk_size[pos];
    endfunction

    task automatic put_header(input int unsigned pos, input bit used,
                              input int unsigned size, input int unsigned prev);
        if (pos < HEAP_WORDS)
        begin
            chunk_used[pos] = used;
            chunk_size[pos] = SIZE_W'(size);
            chunk_prev[pos] = SIZE_W'(prev);
        end
    endtask

    task automatic put_prev(input int unsigned pos, input int unsigned prev);
        if (pos < HEAP_WORDS)
            chunk_prev[pos] = SIZE_W'(prev);
    endtask

    task automatic heap_reset();
        for (int i = 0; i < HEAP_WORDS; i++)
        begin
            chunk_used[i] = 1'b0;
            chunk_size[i] = '0;
            chunk_prev[i] = '0;
        end
        heap_base_q = HEAP_BASE_RESET;
        heap_limit  = PAGE_WORDS;
        put_header(0, 1'b0, HEAD_SIZE, 0);
        put_header(PAGE_WORDS - HEADER_WORDS, 1'b1, 0, HEAD_SIZE);
    endtask

    task automatic heap_alloc(input logic [BYTES_W-1:0] nbytes, output heap_reply_t r);
        int unsigned words, need, pos, pages, grow, csz, rest, nxt;
        bit          found;
        r.address = '0;
        r.status  = ST_OK;
        words = (32'(nbytes) + 7) >> 3;
        need  = words + HEADER_WORDS;
        pos   = 0;
        found = 1'b0;
        // first fit: stop at a free chunk that is big enough or at the tail
        while (!found)
        begin
            if (pos >= HEAP_WORDS)
            begin
                r.status = ST_OOM;
                return;
            end
            if (chunk_size[pos] == 0 || (!chunk_used[pos] && chunk_size[pos] >= need))
                found = 1'b1;
            else
                pos = chunk_end(pos);
        end
        if (chunk_size[pos] == 0)
        begin
            pages = (words + 2 * HEADER_WORDS + PAGE_WORDS - 1) / PAGE_WORDS;
            grow  = pages * PAGE_WORDS;
            csz   = grow - HEADER_WORDS;
            if (heap_limit + grow > HEAP_WORDS)
            begin
                r.status = ST_OOM;
                return;
            end
            // old tail turns into the new chunk, no merge with what precedes it
            chunk_used[pos] = 1'b0;
            chunk_size[pos] = SIZE_W'(csz);
            put_header(pos + grow, 1'b1, 0, csz);
            heap_limit += grow;
        end
        rest = chunk_size[pos] - need;
        chunk_used[pos] = 1'b1;
        if (rest != 0)
        begin
            chunk_size[pos] = SIZE_W'(words);
            nxt = pos + need;
            put_header(nxt, 1'b0, rest, words);
            put_prev(chunk_end(nxt), rest);
        end
        r.address = heap_base_q + (64'(pos + HEADER_WORDS) << 3);
    endtask

    task automatic heap_free(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] off, w;
        int unsigned       target, pos, prv, nxt;
        off = addr - heap_base_q;
        if (off[2:0] != 3'd0)
            return;
        w = off >> 3;
        if (w < HEADER_WORDS || w - HEADER_WORDS >= HEAP_WORDS)
            return;
        target = 32'(w - HEADER_WORDS);
        pos = 0;
        forever
        begin
            if (pos >= HEAP_WORDS || chunk_size[pos] == 0)
                return;
            if (pos == target)
                break;
            if (pos > target)
                return;
            pos = chunk_end(pos);
        end
        if (!chunk_used[pos])
            return;
        chunk_used[pos] = 1'b0;
        if (pos != 0)
        begin
            prv = pos - HEADER_WORDS - chunk_prev[pos];
            if (prv < HEAP_WORDS && !chunk_used[prv])
            begin
                chunk_size[prv] = SIZE_W'(chunk_size[prv] + chunk_size[pos] + HEADER_WORDS);
                pos = prv;
            end
        end
        nxt = chunk_end(pos);
        if (nxt < HEAP_WORDS && !chunk_used[nxt] && chunk_size[nxt] != 0)
            chunk_size[pos] = SIZE_W'(chunk_size[pos] + chunk_size[nxt] + HEADER_WORDS);
        put_prev(chunk_end(pos), chunk_size[pos]);
    endtask

    task automatic heap_request(output heap_reply_t r);
        r.address = '0;
        r.status  = ST_OK;
        if (req.operation == OP_ALLOC)
        begin
            if (req.request_bytes == '0)
                r.status = ST_ZERO;
            else
                heap_alloc(req.request_bytes, r);
        end
        else
        begin
            heap_free(req.free_address);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        heap_reply_t want;
        heap_reply_t got;
        if (!rst_n)
        begin
            heap_reset();
            heap_reply_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                heap_base_q = cfg_wdata;
            // replies first: a word and its own reply never share an edge
            if (rsp.valid && rsp.ready)
            begin
                got.address = rsp.address;
                got.status  = rsp.status;
                if (heap_reply_q.size() == 0)
                begin
                    err_count++;
                    $error("reply with nothing outstanding: address %h status %0d",
                           got.address, got.status);
                end
                else
                begin
                    want = heap_reply_q.pop_front();
                    if (got.address !== want.address)
                    begin
                        err_count++;
                        $error("address: expected %h, actual %h", want.address, got.address);
                    end
                    if (got.status !== want.status)
                    begin
                        err_count++;
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                heap_request(want);
                heap_reply_q.push_back(want);
            end
            pending <= heap_reply_q.size();
        end
        errors <= err_count;
    end

endmodule

/* bench/tb_first_fit_heap_allocator_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_top
// Drives allocate and free words into the heap allocator through a directed
// opening and then random traffic under several heap base settings, with
// random gaps on both channels and one long reply hold-off. The checker
// beside the block judges every reply; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_top;

    import ffa_pkg::*;

    localparam int CLK_PERIOD  = 2;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 600;
    localparam int HOLD_AFTER  = 300;
    localparam int DRAIN_WAIT  = 20;
    localparam int CFG_SETTLE  = 8;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_wdata;
    int                errors;
    int                pending;

    logic [ADDR_W-1:0] base_now;
    logic [ADDR_W-1:0] live_offs  [$];
    logic [ADDR_W-1:0] freed_offs [$];
    bit                sender_calm = 1'b0;

    ffa_req_if req ();
    ffa_rsp_if rsp ();

    always #(CLK_PERIOD / 2) clk = ~clk;

    first_fit_heap_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ffa_heap_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    // payloads handed out, kept as offsets from the base so they survive a rebase
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.address != '0)
            live_offs.push_back(rsp.address - base_now);
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (sender_calm || $urandom_range(1) == 0)
            return 0;
        return gap_len();
    endfunction

    function automatic logic [BYTES_W-1:0] rand_bytes();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return '0;
        if (r < 60)
            return BYTES_W'($urandom_range(1, 128));
        if (r < 87)
            return BYTES_W'($urandom_range(129, 1024));
        if (r < 97)
            return BYTES_W'($urandom_range(1025, 8192));
        return BYTES_W'($urandom_range(8193, 65536));
    endfunction

    function automatic logic [ADDR_W-1:0] bad_address();
        int                r;
        logic [ADDR_W-1:0] off;
        r   = $urandom_range(4);
        off = 64'(8 * (HEADER_WORDS + $urandom_range(0, HEAP_WORDS / 2)));
        if (live_offs.size() != 0)
            off = live_offs[$urandom_range(live_offs.size() - 1)];
        case (r)
            0: return {$urandom, $urandom};
            1: return base_now + off + 64'($urandom_range(1, 7));
            2: return (freed_offs.size() != 0)
                      ? base_now + freed_offs[$urandom_range(freed_offs.size() - 1)]
                      : base_now + 64'(8 * HEADER_WORDS);
            3: return base_now + off + 64'(8 * $urandom_range(1, 4));
            default: return base_now + 64'(8 * $urandom_range(0, HEAP_WORDS + 8));
        endcase
    endfunction

    // one word on the request channel, then a random gap
    task automatic send_word(input logic op, input logic [BYTES_W-1:0] nbytes,
                             input logic [ADDR_W-1:0] faddr);
        int g;
        req.valid         <= 1'b1;
        req.operation     <= op;
        req.request_bytes <= nbytes;
        req.free_address  <= faddr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        g = sender_gap();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic random_word();
        int                r;
        int                k;
        logic [ADDR_W-1:0] off;
        if ($urandom_range(39) == 0)
            sender_calm = !sender_calm;
        r = $urandom_range(99);
        // lean toward frees when many chunks are live, keeps the chain short
        if (live_offs.size() > 40)
            r = r / 2 + 50;
        if (r < 52 || (r < 90 && live_offs.size() == 0))
        begin
            send_word(OP_ALLOC, rand_bytes(), {$urandom, $urandom});
        end
        else if (r < 90)
        begin
            k   = $urandom_range(live_offs.size() - 1);
            off = live_offs[k];
            live_offs.delete(k);
            freed_offs.push_back(off);
            if (freed_offs.size() > 16)
                void'(freed_offs.pop_front());
            send_word(OP_FREE, BYTES_W'($urandom), base_now + off);
        end
        else
        begin
            send_word(OP_FREE, BYTES_W'($urandom), bad_address());
        end
    endtask

    task automatic random_words(input int n);
        repeat (n) random_word();
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_heap_base(input logic [ADDR_W-1:0] v);
        req.valid <= 1'b0;
        wait_drained();
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        base_now  = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // walk through the heap from reset; offsets below follow from the
    // 512-word first page with 3-word headers
    task automatic directed_words();
        logic [ADDR_W-1:0] b;
        b = base_now;
        send_word(OP_ALLOC, '0, '1);                          // zero-size request
        send_word(OP_ALLOC, 17'd4024, '0);                    // takes the head whole
        send_word(OP_ALLOC, 17'd1, '0);                       // grows by one page
        send_word(OP_FREE, 17'h10000, b + 64'd24);
        send_word(OP_ALLOC, 17'd8, '0);
        send_word(OP_ALLOC, 17'd9, '0);
        send_word(OP_ALLOC, 17'd16, '0);
        send_word(OP_FREE, '0, b + 64'd56);
        send_word(OP_FREE, '0, b + 64'd24);                   // merges forward
        send_word(OP_FREE, '0, b + 64'd96);                   // merges both ways
        send_word(OP_FREE, '0, b + 64'd24);                   // already free
        send_word(OP_FREE, '0, b + 64'd25);                   // misaligned
        send_word(OP_FREE, '0, b + 64'd8);                    // inside head area
        send_word(OP_FREE, '0, b + 64'(8 * 1024));            // tail marker
        send_word(OP_FREE, '0, b + 64'(8 * (HEAP_WORDS + HEADER_WORDS)));
        send_word(OP_FREE, '0, b - 64'd8);
        send_word(OP_FREE, '0, b + 64'(8 * 512));
        send_word(OP_ALLOC, 17'h10000, '1);                   // past capacity
        send_word(OP_ALLOC, 17'd9000, '0);                    // grows by three pages
        send_word(OP_ALLOC, 17'd1, '0);
        send_word(OP_FREE, 17'h1FFFF, b + 64'(8 * 1024));
        send_word(OP_FREE, '0, {$urandom, $urandom});
    endtask

    initial
    begin : reply_sink
        int stall;
        int taken;
        bit held;
        bit calm;
        stall = 0;
        taken = 0;
        held  = 1'b0;
        calm  = 1'b0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                taken++;
                if ($urandom_range(31) == 0)
                    calm = !calm;
                if (taken == HOLD_AFTER && !held)
                begin
                    // long hold-off: sender keeps offering, block backs up
                    stall = HOLD_CYCLES;
                    held  = 1'b1;
                end
            end
            if (stall == 0 && !calm && $urandom_range(7) == 0)
                stall = gap_len();
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        req.valid         <= 1'b0;
        req.operation     <= OP_ALLOC;
        req.request_bytes <= '0;
        req.free_address  <= '0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        rst_n             <= 1'b0;
        base_now          = HEAP_BASE_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        directed_words();
        random_words(150);
        write_heap_base('0);
        random_words(160);
        write_heap_base('1);
        random_words(160);
        write_heap_base({$urandom, $urandom});
        random_words(100);
        write_heap_base(64'hffff_8102_0000_0000);
        random_words(80);

        req.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/ffa_pkg.sv
rtl/ffa_req_if.sv
rtl/ffa_rsp_if.sv
rtl/ffa_ram.sv
rtl/first_fit_heap_allocator_top.sv
bench/ffa_heap_checker.sv
bench/tb_first_fit_heap_allocator_top.sv
